// ===== hw/rtl/uhc_pkg.sv =====
`default_nettype none

package uhc_pkg;

    // queue geometry
    localparam int MAX_TAPS = 12;
    localparam int TAP_W    = 4;
    localparam int ORD_W    = 16;
    localparam int DEPTH_W  = 24;
    localparam int PROD_W   = ORD_W + DEPTH_W;
    localparam int GAIN_W   = PROD_W - 16;
    localparam int Q_W      = 28;
    localparam int CFG_W    = 64;

    localparam logic [Q_W-1:0]   QUEUE_MAX     = {Q_W{1'b1}};
    localparam logic [TAP_W-1:0] TAP_COUNT_RST = 4'd10;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TAP_COUNT = 2'd0,
        CFG_TAP_LOW   = 2'd1,
        CFG_TAP_MID   = 2'd2,
        CFG_TAP_HIGH  = 2'd3
    } t_cfg_idx;

    typedef logic [MAX_TAPS-1:0][ORD_W-1:0]  t_ord_vec;
    typedef logic [MAX_TAPS-1:0][GAIN_W-1:0] t_gain_vec;
    typedef logic [Q_W-1:0]                  t_queue [MAX_TAPS];

    // clamp the programmed tap count into 1..MAX_TAPS
    function automatic logic [TAP_W-1:0] active_taps(input logic [TAP_W-1:0] count);
        logic [TAP_W-1:0] n;
        n = count;
        if (n == '0) begin
            n = TAP_W'(1);
        end
        if (n > TAP_W'(MAX_TAPS)) begin
            n = TAP_W'(MAX_TAPS);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/uhc_gain.sv =====
`default_nettype none

module uhc_gain
    import uhc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [DEPTH_W-1:0] i_depth,
    input  wire t_ord_vec           i_ords,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_gain_vec               o_gains
);

    logic               r_v1;
    logic               r_v2;
    logic [DEPTH_W-1:0] r_depth;
    t_gain_vec          r_gain;
    t_gain_vec          n_gain;
    logic               take1;
    logic               take2;

    assign take2   = !r_v2 || i_ready;
    assign take1   = !r_v1 || take2;
    assign o_ready = i_rst_n && take1;
    assign o_valid = r_v2;
    assign o_gains = r_gain;

    // one 16x24 product per tap, keep the bits above the q0.16 point
    always_comb begin
        logic [PROD_W-1:0] prod;
        for (int i = 0; i < MAX_TAPS; i++) begin
            prod      = PROD_W'(i_ords[i]) * PROD_W'(r_depth);
            n_gain[i] = prod[PROD_W-1:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (take1) begin
                r_v1 <= i_valid;
            end
            if (take2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take1 && i_valid) begin
            r_depth <= i_depth;
        end
        if (take2 && r_v1) begin
            r_gain <= n_gain;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/uhc_queue.sv =====
`default_nettype none

module uhc_queue
    import uhc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [TAP_W-1:0] i_tap_count,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_gain_vec        i_gains,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [Q_W-1:0]        o_runoff
);

    t_queue           r_q;
    t_queue           n_q;
    logic [Q_W-1:0]   upd [MAX_TAPS+1];
    logic [Q_W-1:0]   r_out;
    logic             r_out_v;
    logic [TAP_W-1:0] n_act;
    logic             load;

    assign o_ready  = !r_out_v || i_ready;
    assign load     = i_valid && o_ready;
    assign o_valid  = r_out_v;
    assign o_runoff = r_out;
    assign n_act    = active_taps(i_tap_count);

    // saturating accumulate on active entries, then shift down and clear the top
    always_comb begin
        logic [Q_W:0] sum;
        for (int i = 0; i < MAX_TAPS; i++) begin
            sum = {1'b0, r_q[i]} + (Q_W+1)'(i_gains[i]);
            if (TAP_W'(i) < n_act) begin
                upd[i] = sum[Q_W] ? QUEUE_MAX : sum[Q_W-1:0];
            end else begin
                upd[i] = r_q[i];
            end
        end
        upd[MAX_TAPS] = '0;
        for (int i = 0; i < MAX_TAPS; i++) begin
            if (TAP_W'(i) + TAP_W'(1) < n_act) begin
                n_q[i] = upd[i+1];
            end else if (TAP_W'(i) + TAP_W'(1) == n_act) begin
                n_q[i] = '0;
            end else begin
                n_q[i] = r_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_q[i] <= '0;
            end
        end else begin
            if (load) begin
                r_out_v <= 1'b1;
                r_q     <= n_q;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= upd[0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/unit_hydrograph_convolver.sv =====
// unit hydrograph convolver: routes one direct runoff depth (micrometres) per
// transfer to one routed runoff value, as a transposed-form fir over up to
// twelve q0.16 ordinates. an accepted item passes the input register and the
// product register, then the queue update loads the output register; a new
// item is taken every cycle as long as the output side keeps pace; the
// twelve 16x24 products form one registered stage ahead of the queue.
// the user writes ordinates and the tap count on the cfg port only while the
// stream is idle (the block does not enforce this); the queue clears on reset.
`default_nettype none

module unit_hydrograph_convolver
    import uhc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [63:0] i_cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [23:0] runoff_depth
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [27:0] routed_runoff, [31:28] zero
);

    // configuration registers
    logic [TAP_W-1:0] r_tap_count;
    logic [CFG_W-1:0] r_tap_low;
    logic [CFG_W-1:0] r_tap_mid;
    logic [CFG_W-1:0] r_tap_high;

    t_ord_vec         ords;
    t_gain_vec        gains;
    logic             gain_valid;
    logic             gain_ready;
    logic [Q_W-1:0]   runoff;

    // ordinate i sits at bits 16*i of the three concatenated words
    assign ords = {r_tap_high, r_tap_mid, r_tap_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_COUNT_RST;
            r_tap_low   <= '0;
            r_tap_mid   <= '0;
            r_tap_high  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_TAP_COUNT: r_tap_count <= i_cfg_data[TAP_W-1:0];
                CFG_TAP_LOW:   r_tap_low   <= i_cfg_data;
                CFG_TAP_MID:   r_tap_mid   <= i_cfg_data;
                CFG_TAP_HIGH:  r_tap_high  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register and per-tap products
    uhc_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_depth (s_axis_tdata[DEPTH_W-1:0]),
        .i_ords  (ords),
        .o_valid (gain_valid),
        .i_ready (gain_ready),
        .o_gains (gains)
    );

    // pending runoff queue and output register
    uhc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tap_count (r_tap_count),
        .i_valid     (gain_valid),
        .o_ready     (gain_ready),
        .i_gains     (gains),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_runoff    (runoff)
    );

    // pad the 28-bit result up to whole bytes
    assign m_axis_tdata = {4'b0, runoff};

endmodule

`default_nettype wire

// ===== hw/rtl/uhc_checker.sv =====
`default_nettype none

module uhc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // no valid result sets the pad bits, saturated or not
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:28] == 4'b0)
        else $error("pad bits set");

    // a result appears on an empty output only after an accepted input
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
        else $error("result without matching input");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind unit_hydrograph_convolver uhc_checker u_uhc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== verif/unit_hydrograph_convolver_tb.sv =====
module unit_hydrograph_convolver_tb;

    import uhc_pkg::*;

    localparam int SUM_W           = Q_W + 1;
    localparam int OUT_HOLD_CYCLES = 150;   // long receiver hold-off, fills the pipe
    localparam int SETTLE_CYCLES   = 4;     // three-stage pipe plus margin
    localparam int QUIET_LIMIT     = 4000;  // cycles with no transfer or config write before giving up
    localparam int RANDOM_ITEMS    = 600;
    localparam int PRINT_CAP       = 50;

    // tracks the routing queue and the filter settings, and holds the
    // routed runoff values that the block still owes us, oldest first
    class runoff_route_scoreboard;
        logic [TAP_W-1:0] tap_count;
        logic [CFG_W-1:0] ordinate_word [3];
        logic [Q_W-1:0]   pending [MAX_TAPS];
        logic [Q_W-1:0]   routed_due [$];
        int               errors;

        function new();
            tap_count = TAP_COUNT_RST;
            foreach (ordinate_word[g]) ordinate_word[g] = '0;
            foreach (pending[k]) pending[k] = '0;
            errors = 0;
        endfunction

        task report_mismatch(input string what);
            errors++;
            if (errors <= PRINT_CAP) begin
                $display("MISMATCH @%0t: %s", $time, what);
            end
        endtask

        function void write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
            case (idx)
                CFG_TAP_COUNT: tap_count        = value[TAP_W-1:0];
                CFG_TAP_LOW:   ordinate_word[0] = value;
                CFG_TAP_MID:   ordinate_word[1] = value;
                CFG_TAP_HIGH:  ordinate_word[2] = value;
                default: ;
            endcase
        endfunction

        // one time step of the transposed fir: all active entries gain
        // ordinate times depth (q0.16, truncated), entry 0 leaves, the
        // active part shifts down and its top entry clears
        function void route_depth(input logic [DEPTH_W-1:0] depth);
            int               n;
            logic [ORD_W-1:0] ord;
            logic [PROD_W-1:0] gain;
            logic [SUM_W-1:0] sum;
            n = int'(tap_count);
            if (n < 1) n = 1;
            if (n > MAX_TAPS) n = MAX_TAPS;
            for (int k = 0; k < n; k++) begin
                ord  = ordinate_word[k / 4][(k % 4) * ORD_W +: ORD_W];
                gain = (PROD_W'(ord) * PROD_W'(depth)) >> 16;
                sum  = SUM_W'(pending[k]) + SUM_W'(gain);
                if (sum > SUM_W'(QUEUE_MAX)) sum = SUM_W'(QUEUE_MAX);
                pending[k] = sum[Q_W-1:0];
            end
            routed_due.push_back(pending[0]);
            for (int k = 1; k < n; k++) pending[k-1] = pending[k];
            pending[n-1] = '0;
        endfunction

        task check_routed(input logic [31:0] tdata);
            logic [Q_W-1:0] want;
            if (routed_due.size() == 0) begin
                report_mismatch($sformatf("routed runoff 0x%07h with nothing owed",
                                          tdata[Q_W-1:0]));
                return;
            end
            want = routed_due.pop_front();
            if (tdata[Q_W-1:0] !== want) begin
                report_mismatch($sformatf("routed runoff 0x%07h, want 0x%07h",
                                          tdata[Q_W-1:0], want));
            end
            if (tdata[31:Q_W] !== '0) begin
                report_mismatch($sformatf("pad bits 0x%01h not zero", tdata[31:Q_W]));
            end
        endtask

        task check_drained();
            if (routed_due.size() != 0) begin
                report_mismatch($sformatf("%0d routed results never arrived",
                                          routed_due.size()));
            end
        endtask
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [1:0]         i_cfg_addr    = CFG_TAP_COUNT;
    logic [CFG_W-1:0]   i_cfg_data    = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [23:0]        s_axis_tdata  = '0;    // [23:0] runoff_depth
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [31:0]        m_axis_tdata;          // [27:0] routed_runoff, [31:28] zero

    runoff_route_scoreboard sb;
    bit no_idle      = 1'b0;   // both sides run without gaps while set
    bit out_hold_req = 1'b0;   // asks the receiver for one long hold-off
    int quiet_cycles = 0;

    unit_hydrograph_convolver i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // gap length: mostly none, often short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // depths lean on the extremes and on small values, the rest full range
    function automatic logic [DEPTH_W-1:0] pick_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '1;
        if (r < 16) return '0;
        if (r < 40) return DEPTH_W'($urandom_range(0, 4095));
        return DEPTH_W'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] pick_word();
        logic [CFG_W-1:0] w;
        int r;
        r = $urandom_range(0, 9);
        w = {$urandom, $urandom};
        if (r == 0) begin
            w = '1;
        end else if (r == 1) begin
            w = '0;
        end else if (r < 4) begin
            // small ordinates, closer to a real unit hydrograph
            for (int k = 0; k < 4; k++) w[k * ORD_W +: ORD_W] = ORD_W'($urandom_range(0, 4095));
        end
        return w;
    endfunction

    // tap counts cover the clamped codes on both sides as well as the range
    function automatic logic [TAP_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return TAP_W'(1);
            2:       return TAP_W'(MAX_TAPS);
            3:       return '1;
            default: return TAP_W'($urandom_range(0, 15));
        endcase
    endfunction

    // scoreboard taps: config writes, accepted depths, accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(t_cfg_idx'(i_cfg_addr), i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) sb.route_depth(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_routed(m_axis_tdata);
        end
    end

    // watchdog: any transfer or config write counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (out_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (OUT_HOLD_CYCLES) @(posedge i_clk);
                out_hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (stall - 1) @(posedge i_clk);
                end
            end
        end
    end

    // offer one depth after a random gap, return once it is transferred;
    // tvalid stays high into the next call when that one has no gap
    task automatic send_depth(input logic [DEPTH_W-1:0] depth);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= depth;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // stop sending and wait until every owed result has come out; the first
    // edge lets the scoreboard note the last transfer before the count is read
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.routed_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // rewrite all four registers on an idle block; upper bits of the
    // count word carry junk that the block must drop
    task automatic reprogram_filter(input logic [TAP_W-1:0] count,
                                    input logic [CFG_W-1:0] lo, mid, hi);
        logic [CFG_W-1:0] count_word;
        wait_drained();
        count_word = {$urandom, $urandom};
        count_word[TAP_W-1:0] = count;
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_TAP_COUNT;
        i_cfg_data <= count_word;
        @(posedge i_clk);
        i_cfg_addr <= CFG_TAP_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_addr <= CFG_TAP_MID;
        i_cfg_data <= mid;
        @(posedge i_clk);
        i_cfg_addr <= CFG_TAP_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] w_lo;
        logic [CFG_W-1:0] w_mid;
        logic [CFG_W-1:0] w_hi;
        int               sent;
        int               burst;
        bit               pressed;

        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero ordinates, everything routes to zero
        send_depth('1);
        send_depth('0);

        // all taps at full scale, depth extremes and alternating bits
        reprogram_filter(TAP_W'(MAX_TAPS), '1, '1, '1);
        repeat (5) send_depth('1);
        send_depth(24'h000001);
        send_depth(24'hAAAAAA);
        send_depth(24'h555555);
        send_depth('0);

        // count of zero behaves as a single tap
        reprogram_filter('0, 64'h1234_5678_9ABC_FFFF, '1, '1);
        send_depth('1);
        send_depth(24'h800000);
        send_depth(24'h000001);

        // count just past the top clamps to all taps
        w_lo  = 64'h8000_0001_4000_FFFF;
        w_mid = 64'h0100_FFFF_0000_2000;
        w_hi  = 64'hFFFF_0010_7FFF_0800;
        reprogram_filter(TAP_W'(MAX_TAPS + 1), w_lo, w_mid, w_hi);
        send_depth('1);
        send_depth(24'h123456);
        send_depth('0);

        // shrink: entries above the count freeze with what they hold
        reprogram_filter(TAP_W'(2), w_lo, w_mid, w_hi);
        send_depth('1);
        send_depth('1);

        // grow again through the top code: frozen entries come back
        reprogram_filter('1, w_lo, w_mid, w_hi);
        send_depth('0);
        send_depth('0);

        // random phases, reprogrammed with mostly fresh settings; the first one runs the
        // pressure case with the receiver parked and the sender pushing
        sent    = 0;
        pressed = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                w_lo  = pick_word();
                w_mid = pick_word();
                w_hi  = pick_word();
            end
            reprogram_filter(pick_count(), w_lo, w_mid, w_hi);
            burst   = $urandom_range(10, 60);
            no_idle = ($urandom_range(0, 4) == 0);
            if (!pressed) begin
                pressed      = 1'b1;
                no_idle      = 1'b1;
                burst        = 40;
                out_hold_req = 1'b1;
            end
            repeat (burst) send_depth(pick_depth());
            sent    = sent + burst;
            no_idle = 1'b0;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== unit_hydrograph_convolver.f =====
hw/rtl/uhc_pkg.sv
hw/rtl/uhc_gain.sv
hw/rtl/uhc_queue.sv
hw/rtl/unit_hydrograph_convolver.sv
hw/rtl/uhc_checker.sv
verif/unit_hydrograph_convolver_tb.sv
